[hdl/assert_macros.svh]
// Assertion macros shared by the supply level supervisor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SLSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked check that also runs through reset.
`define SLSV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/slsv_pkg.sv]
// Package: types, codes and reset values of the supply level supervisor.
package slsv_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned LevelBits  = 3;
  localparam int unsigned TrendBits  = 4;
  localparam int unsigned AddrBits   = 5;
  localparam int unsigned DataBits   = 32;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [LevelBits-1:0]  level_t;
  typedef logic [TrendBits-1:0]  trend_t;

  // Item actions
  typedef enum logic [1:0] {
    ActSample    = 2'd0,
    ActClearChg  = 2'd1,
    ActWriteDone = 2'd2
  } action_e;

  // Supply levels
  localparam level_t LvlInit     = 3'd0;
  localparam level_t LvlNoLow    = 3'd1;
  localparam level_t LvlPartLow  = 3'd2;
  localparam level_t LvlFull     = 3'd3;
  localparam level_t LvlPartHigh = 3'd4;
  localparam level_t LvlNoHigh   = 3'd5;

  localparam trend_t TrendNone = 4'd0;

  // Register indexes (byte address / 4)
  localparam logic [2:0] RegThr4v2  = 3'd0;
  localparam logic [2:0] RegThr4v5  = 3'd1;
  localparam logic [2:0] RegThr6v0  = 3'd2;
  localparam logic [2:0] RegThr6v5  = 3'd3;
  localparam logic [2:0] RegThr18v0 = 3'd4;
  localparam logic [2:0] RegThr18v5 = 3'd5;
  localparam logic [2:0] RegThr26v5 = 3'd6;
  localparam logic [2:0] RegThr27v0 = 3'd7;

  localparam sample_t Thr4v2Rst  = SampleBits'(573);
  localparam sample_t Thr4v5Rst  = SampleBits'(614);
  localparam sample_t Thr6v0Rst  = SampleBits'(819);
  localparam sample_t Thr6v5Rst  = SampleBits'(887);
  localparam sample_t Thr18v0Rst = SampleBits'(2458);
  localparam sample_t Thr18v5Rst = SampleBits'(2526);
  localparam sample_t Thr26v5Rst = SampleBits'(3618);
  localparam sample_t Thr27v0Rst = SampleBits'(3686);

  typedef struct packed {
    sample_t thr_4v2;
    sample_t thr_4v5;
    sample_t thr_6v0;
    sample_t thr_6v5;
    sample_t thr_18v0;
    sample_t thr_18v5;
    sample_t thr_26v5;
    sample_t thr_27v0;
  } thr_set_t;

  typedef struct packed {
    logic [1:0] action;
    sample_t    sample;
    logic       done_value;
  } in_beat_t;

  typedef struct packed {
    level_t level;
    trend_t tendency;
    logic   change_flag;
    logic   seq_done;
    logic   stepped;
  } out_beat_t;

  // Tendency table: entry i holds i + 1.
  function automatic trend_t trend_lookup(logic [2:0] idx);
    trend_lookup = {1'b0, idx} + trend_t'(1);
  endfunction

endpackage

[hdl/slsv_cfg_regs.sv]
// Threshold register file behind the APB-style configuration port.
module slsv_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slsv_pkg::AddrBits-1:0]  paddr,
  input  logic [slsv_pkg::DataBits-1:0]  pwdata,
  output logic [slsv_pkg::DataBits-1:0]  prdata,
  output logic                           pready,
  output slsv_pkg::thr_set_t             thr_o
);
  import slsv_pkg::*;

  thr_set_t   thr_q, thr_d;
  logic [2:0] reg_idx;
  sample_t    wr_val;
  sample_t    rd_val;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrBits-1:2];
  assign wr_val  = pwdata[SampleBits-1:0];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    thr_d = thr_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegThr4v2:  thr_d.thr_4v2  = wr_val;
        RegThr4v5:  thr_d.thr_4v5  = wr_val;
        RegThr6v0:  thr_d.thr_6v0  = wr_val;
        RegThr6v5:  thr_d.thr_6v5  = wr_val;
        RegThr18v0: thr_d.thr_18v0 = wr_val;
        RegThr18v5: thr_d.thr_18v5 = wr_val;
        RegThr26v5: thr_d.thr_26v5 = wr_val;
        RegThr27v0: thr_d.thr_27v0 = wr_val;
        default:    thr_d = thr_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegThr4v2:  rd_val = thr_q.thr_4v2;
      RegThr4v5:  rd_val = thr_q.thr_4v5;
      RegThr6v0:  rd_val = thr_q.thr_6v0;
      RegThr6v5:  rd_val = thr_q.thr_6v5;
      RegThr18v0: rd_val = thr_q.thr_18v0;
      RegThr18v5: rd_val = thr_q.thr_18v5;
      RegThr26v5: rd_val = thr_q.thr_26v5;
      RegThr27v0: rd_val = thr_q.thr_27v0;
      default:    rd_val = '0;
    endcase
  end

  assign prdata = DataBits'(rd_val);
  assign thr_o  = thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.thr_4v2  <= Thr4v2Rst;
      thr_q.thr_4v5  <= Thr4v5Rst;
      thr_q.thr_6v0  <= Thr6v0Rst;
      thr_q.thr_6v5  <= Thr6v5Rst;
      thr_q.thr_18v0 <= Thr18v0Rst;
      thr_q.thr_18v5 <= Thr18v5Rst;
      thr_q.thr_26v5 <= Thr26v5Rst;
      thr_q.thr_27v0 <= Thr27v0Rst;
    end else begin
      thr_q <= thr_d;
    end
  end

endmodule

[hdl/slsv_classify.sv]
// Band classifier: maps a sample and the current level to a target level.
module slsv_classify (
  input  slsv_pkg::sample_t  sample_i,
  input  slsv_pkg::level_t   level_i,
  input  slsv_pkg::thr_set_t thr_i,
  output slsv_pkg::level_t   target_o
);
  import slsv_pkg::*;

  // Bands are tested top down; the narrow ones are hysteresis windows.
  always_comb begin
    priority if (thr_i.thr_26v5 < sample_i && sample_i < thr_i.thr_27v0) begin
      target_o = (level_i < LvlPartHigh) ? LvlPartHigh : level_i;
    end else if (thr_i.thr_18v5 <= sample_i && sample_i <= thr_i.thr_26v5) begin
      target_o = LvlPartHigh;
    end else if (thr_i.thr_18v0 < sample_i && sample_i < thr_i.thr_18v5) begin
      target_o = (level_i <= LvlFull) ? LvlFull : LvlPartHigh;
    end else if (thr_i.thr_6v5 <= sample_i && sample_i <= thr_i.thr_18v0) begin
      target_o = LvlFull;
    end else if (thr_i.thr_6v0 < sample_i && sample_i < thr_i.thr_6v5) begin
      target_o = (level_i <= LvlPartLow) ? LvlPartLow : LvlFull;
    end else if (thr_i.thr_4v5 <= sample_i && sample_i <= thr_i.thr_6v0) begin
      target_o = LvlPartLow;
    end else if (thr_i.thr_4v2 < sample_i && sample_i < thr_i.thr_4v5) begin
      target_o = (level_i > LvlPartLow) ? LvlPartLow : level_i;
    end else if (sample_i <= thr_i.thr_4v2) begin
      target_o = LvlNoLow;
    end else begin
      target_o = LvlNoHigh;
    end
  end

endmodule

[hdl/slsv_level.sv]
// Level state: current and previous level, tendency, change and done flags.
module slsv_level (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  slsv_pkg::in_beat_t  beat_i,
  input  slsv_pkg::level_t    target_i,
  output slsv_pkg::level_t    level_o,
  output slsv_pkg::out_beat_t result_o
);
  import slsv_pkg::*;

  level_t     cur_q, cur_d, prev_q, prev_d, base;
  trend_t     trend_q, trend_d;
  logic       changed_q, changed_d, done_q, done_d;
  logic       move;
  logic [2:0] trend_idx;

  assign base = (cur_q == LvlInit) ? LvlFull : cur_q;

  always_comb begin
    cur_d     = cur_q;
    prev_d    = prev_q;
    trend_d   = trend_q;
    changed_d = changed_q;
    done_d    = done_q;
    move      = 1'b0;
    trend_idx = '0;
    unique case (beat_i.action)
      ActSample: begin
        cur_d = base;
        if (base != target_i && done_q) begin
          move      = 1'b1;
          prev_d    = base;
          changed_d = 1'b1;
          done_d    = 1'b0;
          cur_d     = (base > target_i) ? base - level_t'(1) : base + level_t'(1);
          // Up steps index from partial low, down steps from no-op low.
          trend_idx = (cur_d > base) ? cur_d - 3'd2 : cur_d + 3'd3;
          trend_d   = trend_lookup(trend_idx);
        end
      end
      ActClearChg:  changed_d = 1'b0;
      ActWriteDone: done_d    = beat_i.done_value;
      default:      cur_d     = cur_q;
    endcase
  end

  assign level_o              = cur_q;
  assign result_o.level       = cur_d;
  assign result_o.tendency    = trend_d;
  assign result_o.change_flag = changed_d;
  assign result_o.seq_done    = done_d;
  assign result_o.stepped     = move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= LvlInit;
      prev_q    <= LvlInit;
      trend_q   <= TrendNone;
      changed_q <= 1'b1;
      done_q    <= 1'b1;
    end else if (fire_i) begin
      cur_q     <= cur_d;
      prev_q    <= prev_d;
      trend_q   <= trend_d;
      changed_q <= changed_d;
      done_q    <= done_d;
    end
  end

endmodule

[hdl/supply_level_supervisor_core.sv]
// Top level of the supply level supervisor: channels, pipeline registers, checks.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one beat per
//   item: a sample, a clear of the change flag, or a write of the done flag.
//   Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly
//   one beat per item with the level, tendency and flags after that item.
//   Thresholds sit in eight 12-bit registers on the APB-style port at byte
//   addresses 0x00..0x1C; write them only while no item is in flight.
// Timing:
//   An item is held in the input register, classified and applied to the
//   level state when the output register is empty or draining, and its
//   result is loaded into the output register as the level state updates.
//   Throughput is one item per cycle while out_ready_i stays high.
// Reset:
//   Thresholds return to their defaults, level goes to init, tendency to
//   none, change and done flags to set; both pipeline registers empty.
// Stall:
//   While out_ready_i is low the result beat holds in the output register,
//   one more item waits in the input register, then in_ready_o drops.
module supply_level_supervisor_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  slsv_pkg::in_beat_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output slsv_pkg::out_beat_t            out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slsv_pkg::AddrBits-1:0]  paddr,
  input  logic [slsv_pkg::DataBits-1:0]  pwdata,
  output logic [slsv_pkg::DataBits-1:0]  prdata,
  output logic                           pready
);
  import slsv_pkg::*;
  `include "assert_macros.svh"

  thr_set_t  thr;
  in_beat_t  in_q;
  logic      in_valid_q;
  out_beat_t out_q, result;
  logic      out_valid_q;
  logic      out_free, adv;
  level_t    cur_level, target;
  logic      out_step, step_flags_ok;

  // Advance the held item whenever the output register is empty or draining.
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  slsv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr_o   (thr)
  );

  slsv_classify u_classify (
    .sample_i (in_q.sample),
    .level_i  (cur_level),
    .thr_i    (thr),
    .target_o (target)
  );

  slsv_level u_level (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (adv),
    .beat_i   (in_q),
    .target_i (target),
    .level_o  (cur_level),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_step      = out_valid_o && out_data_o.stepped;
  assign step_flags_ok = out_data_o.change_flag && !out_data_o.seq_done
                         && (out_data_o.level != LvlInit);

  // A step always sets the change flag, clears the done flag and leaves init.
  `SLSV_ASSERT(a_step_flags, out_step |-> step_flags_ok, "step beat with wrong flags or level")
  // A step always carries a tendency code.
  `SLSV_ASSERT(a_step_trend, out_step |-> out_data_o.tendency != TrendNone, "no tendency on step")
  // A ready sink never blocks the source.
  `SLSV_ASSERT(a_no_bubble, out_ready_i |-> in_ready_o, "input stalled while output drains")
  // The output register holds no valid beat while reset stays asserted.
  `SLSV_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!out_valid_q || rst_ni), "valid during reset")

endmodule
